FILE: hdl/screen2_line_two_color_encoder_assert.svh
// Assertion macros used by the encoder RTL.
// Each check samples on the rising edge of the given clock and is off while
// the active-low reset is asserted.
`ifndef SCREEN2_LINE_TWO_COLOR_ENCODER_ASSERT_SVH
`define SCREEN2_LINE_TWO_COLOR_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define SCR2LTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scr2lte check failed");

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define SCR2LTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scr2lte check failed");

`else

`define SCR2LTE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SCR2LTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/scr2lte_pkg.sv
package scr2lte_pkg;

  localparam int NUM_PIX    = 8;
  localparam int COLOR_W    = 4;
  localparam int NUM_COLORS = 16;
  localparam int ERR_W      = 18;  // 3 * 255 * 255 fits in 18 bits
  localparam int SUM_W      = 21;  // eight of those fit in 21 bits
  localparam int IN_W       = NUM_PIX * COLOR_W;
  localparam int OUT_W      = 8 + 2 * COLOR_W;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [ERR_W-1:0]   err_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [NUM_PIX-1:0] pat_t;

  localparam color_t FIRST_LO  = color_t'(1);
  localparam color_t FIRST_HI  = color_t'(2);
  localparam color_t TOP_COLOR = color_t'(NUM_COLORS - 1);
  localparam color_t LAST_LO   = color_t'(NUM_COLORS - 2);

  // Palette entries as 0xRRGGBB, entry 15 first.
  localparam logic [NUM_COLORS-1:0][23:0] PALETTE = {
    24'hFFFFFF, 24'hCCCCCC, 24'hC95BBA, 24'h21B03B,
    24'hE6CE80, 24'hD4C154, 24'hFF7978, 24'hFC5554,
    24'h42EBF5, 24'hD4524D, 24'h7D76FC, 24'h5455ED,
    24'h5EDC78, 24'h21C842, 24'h000000, 24'h000000
  };

  typedef logic [NUM_COLORS*NUM_COLORS-1:0][ERR_W-1:0] dist_tbl_t;

  // Squared RGB distance for every pair of palette entries, indexed by
  // {first index, second index}. Built once at elaboration.
  function automatic dist_tbl_t build_dist_tbl();
    dist_tbl_t tbl;
    int a;
    int b;
    int dr;
    int dg;
    int db;
    for (a = 0; a < NUM_COLORS; a++) begin
      for (b = 0; b < NUM_COLORS; b++) begin
        dr = int'(PALETTE[a][23:16]) - int'(PALETTE[b][23:16]);
        dg = int'(PALETTE[a][15:8])  - int'(PALETTE[b][15:8]);
        db = int'(PALETTE[a][7:0])   - int'(PALETTE[b][7:0]);
        tbl[a*NUM_COLORS + b] = ERR_W'(dr*dr + dg*dg + db*db);
      end
    end
    return tbl;
  endfunction

  localparam dist_tbl_t DIST_TBL = build_dist_tbl();

endpackage

FILE: hdl/screen2_line_two_color_encoder.sv
// Channel  | Direction | Handshake           | Contents of one word
// ---------+-----------+---------------------+-----------------------------------------
// in_      | input     | in_tvalid/in_tready  | in_tdata: eight 4-bit pixel indices
// out_     | output    | out_tvalid/out_tready| out_tdata: pattern, high and low color
//
// A word is handled in order: the shared pair evaluator takes one color pair per cycle
// through all 105 pairs, its two stages drain and the best pair settles, and then the
// output register is loaded. The pair loop dominates the time; the next word is taken
// only once the sequencer is back in idle, after the result has been loaded.
// Reset (rst_n low, synchronous) empties the pipeline and the output. A result that is not
// taken stays in the output register while the next word runs, and that one waits for it.
`include "screen2_line_two_color_encoder_assert.svh"

module screen2_line_two_color_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel_0 [3:0], pixel_1 [7:4], ... pixel_7 [31:28]
  input  logic [scr2lte_pkg::IN_W-1:0]  in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pattern_bits [7:0], high_color [11:8], low_color [15:12]
  output logic [scr2lte_pkg::OUT_W-1:0] out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready
);

  // Sequencer states: wait for a word, sweep the pairs, drain the
  // evaluator pipeline, then hand the best pair to the output register.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Pair counters driving the evaluator.
  scr2lte_pkg::color_t lo_r, lo_nxt;
  scr2lte_pkg::color_t hi_r, hi_nxt;
  logic                issue;
  logic                out_load;
  logic                in_accept;

  // The row being encoded.
  scr2lte_pkg::color_t px_r [scr2lte_pkg::NUM_PIX];

  // Stage 1: per-pixel choice and error for the issued pair.
  logic                s1_valid_r;
  scr2lte_pkg::err_t   s1_err_r [scr2lte_pkg::NUM_PIX];
  scr2lte_pkg::pat_t   s1_pat_r;
  scr2lte_pkg::color_t s1_lo_r;
  scr2lte_pkg::color_t s1_hi_r;

  // Stage 2: summed error of the pair.
  logic                s2_valid_r;
  scr2lte_pkg::sum_t   s2_sum_r;
  scr2lte_pkg::pat_t   s2_pat_r;
  scr2lte_pkg::color_t s2_lo_r;
  scr2lte_pkg::color_t s2_hi_r;

  // Running best pair.
  scr2lte_pkg::sum_t   best_err_r;
  scr2lte_pkg::pat_t   best_pat_r;
  scr2lte_pkg::color_t best_lo_r;
  scr2lte_pkg::color_t best_hi_r;

  logic                out_tvalid_r;
  logic [scr2lte_pkg::OUT_W-1:0] out_data_r;

  scr2lte_pkg::err_t   pix_err [scr2lte_pkg::NUM_PIX];
  scr2lte_pkg::pat_t   pix_pat;
  scr2lte_pkg::sum_t   err_sum;
  logic                s2_first;
  logic                take_best;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Sequencer: the pairs run low 1..14 and, for each, high low+1..15.
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_RUN;
          lo_nxt    = scr2lte_pkg::FIRST_LO;
          hi_nxt    = scr2lte_pkg::FIRST_HI;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (hi_r == scr2lte_pkg::TOP_COLOR) begin
          if (lo_r == scr2lte_pkg::LAST_LO) begin
            state_nxt = ST_FLUSH;
          end else begin
            lo_nxt = lo_r + scr2lte_pkg::color_t'(1);
            hi_nxt = lo_r + scr2lte_pkg::color_t'(2);
          end
        end else begin
          hi_nxt = hi_r + scr2lte_pkg::color_t'(1);
        end
      end
      ST_FLUSH: begin
        // The best pair is final once both evaluator stages are empty.
        if (!s1_valid_r && !s2_valid_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lo_r         <= scr2lte_pkg::FIRST_LO;
      hi_r         <= scr2lte_pkg::FIRST_HI;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_data_r   <= {best_lo_r, best_hi_r, best_pat_r};
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < scr2lte_pkg::NUM_PIX; i++) begin
        px_r[i] <= in_tdata[i*scr2lte_pkg::COLOR_W +: scr2lte_pkg::COLOR_W];
      end
    end
  end

  // Shared pair evaluator, stage 1: every pixel looks up its distance to
  // both colors and keeps the nearer one; a tie stays with the low color.
  // Pixel 0 lands in the most significant pattern bit.
  always_comb begin
    scr2lte_pkg::err_t e_lo;
    scr2lte_pkg::err_t e_hi;
    pix_pat = '0;
    for (int i = 0; i < scr2lte_pkg::NUM_PIX; i++) begin
      e_lo = scr2lte_pkg::DIST_TBL[{px_r[i], lo_r}];
      e_hi = scr2lte_pkg::DIST_TBL[{px_r[i], hi_r}];
      pix_pat[scr2lte_pkg::NUM_PIX-1-i] = (e_lo > e_hi);
      pix_err[i] = (e_lo > e_hi) ? e_hi : e_lo;
    end
  end

  // Stage 2: error of the whole row for this pair.
  always_comb begin
    err_sum = '0;
    for (int i = 0; i < scr2lte_pkg::NUM_PIX; i++) begin
      err_sum = err_sum + scr2lte_pkg::sum_t'(s1_err_r[i]);
    end
  end

  // Stage 3: the first pair always seeds the best; later ones must be
  // strictly better, so earlier pairs win ties.
  assign s2_first  = (s2_lo_r == scr2lte_pkg::FIRST_LO) &&
                     (s2_hi_r == scr2lte_pkg::FIRST_HI);
  assign take_best = s2_valid_r && (s2_first || (s2_sum_r < best_err_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_err_r <= pix_err;
    s1_pat_r <= pix_pat;
    s1_lo_r  <= lo_r;
    s1_hi_r  <= hi_r;
    s2_sum_r <= err_sum;
    s2_pat_r <= s1_pat_r;
    s2_lo_r  <= s1_lo_r;
    s2_hi_r  <= s1_hi_r;
    if (take_best) begin
      best_err_r <= s2_sum_r;
      best_pat_r <= s2_pat_r;
      best_lo_r  <= s2_lo_r;
      best_hi_r  <= s2_hi_r;
    end
  end

  // An accepted word always starts the sweep at the first pair.
  `SCR2LTE_ASSERT_NEXT(a_start_pair, clk, rst_n, in_accept,
    (state_r == ST_RUN) && (lo_r == scr2lte_pkg::FIRST_LO) && (hi_r == scr2lte_pkg::FIRST_HI))
  // Pairs in the evaluator are ordered and never use color zero.
  `SCR2LTE_ASSERT_IMPL(a_pair_order, clk, rst_n, s2_valid_r,
    (s2_lo_r != '0) && (s2_lo_r < s2_hi_r))
  // The evaluator is empty whenever the sequencer is waiting for a word.
  `SCR2LTE_ASSERT_IMPL(a_idle_empty, clk, rst_n, state_r == ST_IDLE,
    !s1_valid_r && !s2_valid_r)
  // A new result is offered only from the hand-over state.
  `SCR2LTE_ASSERT_IMPL(a_result_src, clk, rst_n, $rose(out_tvalid_r),
    $past(state_r == ST_DONE))
  // A result never names the same color twice.
  `SCR2LTE_ASSERT_IMPL(a_out_colors, clk, rst_n, out_tvalid_r,
    out_data_r[15:12] < out_data_r[11:8])

endmodule

FILE: test/screen2_line_two_color_encoder_test.sv
module screen2_line_two_color_encoder_test;

  // One winning color pair for a row, laid out the same way as out_tdata.
  typedef struct packed {
    logic [3:0] low;
    logic [3:0] high;
    logic [7:0] pattern;
  } pick_t;

  // Palette as 0xRRGGBB, index 0 first. Entries 0 and 1 are both black.
  localparam logic [23:0] SWATCH [16] = '{
    24'h000000, 24'h000000, 24'h21C842, 24'h5EDC78,
    24'h5455ED, 24'h7D76FC, 24'hD4524D, 24'h42EBF5,
    24'hFC5554, 24'hFF7978, 24'hD4C154, 24'hE6CE80,
    24'h21B03B, 24'hC95BBA, 24'hCCCCCC, 24'hFFFFFF
  };

  localparam int RANDOM_ROWS = 1800;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic [scr2lte_pkg::IN_W-1:0]  in_tdata   = '0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [scr2lte_pkg::OUT_W-1:0] out_tdata;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;

  // While steady is set neither side idles.
  bit    steady   = 1'b0;
  int    failures = 0;
  pick_t expected_picks [$];

  screen2_line_two_color_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random, about 15 percent of the time, unless steady is set.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 15);
  end

  // Squared RGB distance between two palette entries.
  function automatic int unsigned color_dist(input logic [3:0] a, input logic [3:0] b);
    int dr;
    int dg;
    int db;
    dr = int'(SWATCH[a][23:16]) - int'(SWATCH[b][23:16]);
    dg = int'(SWATCH[a][15:8])  - int'(SWATCH[b][15:8]);
    db = int'(SWATCH[a][7:0])   - int'(SWATCH[b][7:0]);
    return int'(dr * dr + dg * dg + db * db);
  endfunction

  // Exhaustive search over all 105 pairs. The running best starts above any
  // reachable sum, so pair (1,2) always becomes the first candidate, and a
  // strict less-than keeps the earliest pair on equal sums.
  function automatic pick_t pick_pair(input logic [31:0] row);
    pick_t       best;
    int unsigned best_err;
    int unsigned err;
    int unsigned e_lo;
    int unsigned e_hi;
    logic [7:0]  pat;
    logic [3:0]  px;
    best     = '0;
    best_err = 32'hFFFF_FFFF;
    for (int lo = 1; lo < 15; lo++) begin
      for (int hi = lo + 1; hi < 16; hi++) begin
        err = 0;
        pat = '0;
        for (int i = 0; i < 8; i++) begin
          px   = row[4*i +: 4];
          e_lo = color_dist(px, 4'(lo));
          e_hi = color_dist(px, 4'(hi));
          // A pixel equally far from both colors stays on the low one.
          pat  = {pat[6:0], e_lo > e_hi};
          err += (e_lo > e_hi) ? e_hi : e_lo;
        end
        if (err < best_err) begin
          best_err     = err;
          best.pattern = pat;
          best.high    = 4'(hi);
          best.low     = 4'(lo);
        end
      end
    end
    return best;
  endfunction

  // Offers one row, with a random idle gap in front unless steady is set,
  // and records the expected pick once the row is taken. The valid stays
  // high after acceptance so back-to-back rows need no extra step.
  task automatic send_row(input logic [31:0] row);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 15) gap++;
      // Now and then a long pause lets the block drain, so later rows land
      // on a different phase of the output stalls.
      if ($urandom_range(99) < 3) gap += $urandom_range(1, 120);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_picks.push_back(pick_pair(row));
  endtask

  function automatic logic [31:0] fill_row(input logic [3:0] c);
    return {8{c}};
  endfunction

  // Rows that hit the field extremes and push every bit of every pixel both
  // ways: solid rows, ramps both ways, alternating black/white and mixed rows.
  task automatic test_corner_rows();
    send_row(fill_row(4'd0));
    send_row(fill_row(4'd15));
    send_row(fill_row(4'd2));
    send_row(fill_row(4'd7));
    send_row(32'h7654_3210);
    send_row(32'hFEDC_BA98);
    send_row(32'h0123_4567);
    send_row(32'h89AB_CDEF);
    send_row(32'hF0F0_F0F0);
    send_row(32'h0F0F_0F0F);
    send_row(32'h8686_6868);
    send_row(32'hE4A9_3D5B);
  endtask

  // Rows where several pairs reach the same error or a pixel sits on a tie:
  // index zero against index one, two near-identical greens, and pure rows
  // whose color belongs to many zero-error pairs.
  task automatic test_tie_rows();
    send_row(fill_row(4'd1));
    send_row(32'h1010_0101);
    send_row(32'hF101_0F10);
    send_row(32'h2C2C_C2C2);
    send_row(32'h000F_F000);
    send_row(fill_row(4'd14));
    send_row(32'h0E0E_1E1E);
    send_row(32'hC22C_0110);
  endtask

  // Mostly rows built from two or three colors, which is what the encoder
  // is meant for, plus fully random rows. A middle stretch runs with no
  // idling on either side.
  task automatic test_random_rows();
    logic [31:0] row;
    logic [3:0]  shade [3];
    int          kind;
    for (int k = 0; k < RANDOM_ROWS; k++) begin
      steady = (k >= 700) && (k < 1000);
      kind   = $urandom_range(9);
      for (int j = 0; j < 3; j++) shade[j] = 4'($urandom_range(15));
      for (int i = 0; i < 8; i++) begin
        if (kind < 3)
          row[4*i +: 4] = 4'($urandom_range(15));
        else if (kind < 8)
          row[4*i +: 4] = shade[$urandom_range(1)];
        else
          row[4*i +: 4] = shade[$urandom_range(2)];
      end
      send_row(row);
    end
    steady = 1'b0;
  endtask

  // Every result that leaves the block is matched against the oldest pick.
  always @(posedge clk) begin : check_results
    pick_t want;
    pick_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = pick_t'(out_tdata[15:0]);
      if (expected_picks.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %04h", $time, got);
        failures++;
      end else begin
        want = expected_picks.pop_front();
        if (got.pattern !== want.pattern) begin
          $display("%0t: pattern expected %02h, got %02h", $time, want.pattern, got.pattern);
          failures++;
        end
        if (got.high !== want.high) begin
          $display("%0t: high color expected %0d, got %0d", $time, want.high, got.high);
          failures++;
        end
        if (got.low !== want.low) begin
          $display("%0t: low color expected %0d, got %0d", $time, want.low, got.low);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_rows();
    test_tie_rows();
    test_random_rows();
    in_tvalid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    // Wait longer than one row takes, so anything extra shows up by then.
    repeat (150) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Roughly ten times the slowest expected run.
  initial begin
    #25_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
